FILE: rtl/ps128_pkg.sv
`default_nettype none
package ps128_pkg;
    typedef enum logic [4:0] {
        OP_SPLAT = 5'd0, OP_NOT = 5'd1, OP_ABS = 5'd2, OP_NEG = 5'd3, OP_SQRT = 5'd4,
        OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_ADD = 5'd8, OP_SUB = 5'd9,
        OP_MUL = 5'd10, OP_DIV = 5'd11, OP_EQ = 5'd12, OP_NE = 5'd13, OP_LT = 5'd14,
        OP_LE = 5'd15, OP_GT = 5'd16, OP_GE = 5'd17, OP_SHL = 5'd18, OP_SHR = 5'd19,
        OP_SEL = 5'd20
    } op_t;

    localparam logic [3:0] KIND_U64 = 4'd7;
    localparam logic [3:0] KIND_INT_END = 4'd8;
    localparam logic [3:0] KIND_BOOL = 4'd10;

    localparam int IN_TDATA_W = 432;
    localparam int OUT_TDATA_W = 136;

    typedef struct packed {
        logic [31:0] shift_count;
        logic [63:0] c_hi;
        logic [63:0] c_lo;
        logic [63:0] b_hi;
        logic [63:0] b_lo;
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic        is_mask;
        logic [3:0]  elem_kind;
        logic [4:0]  opcode;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } result_t;
endpackage
`default_nettype wire

FILE: rtl/packed_simd128_alu.sv
`default_nettype none
// Pipeline: an accepted item is held in the input register, then moves into the result register.
// Throughput: one item per cycle while m_tready stays high; input stage advances whenever the result slot frees.
// Multiply builds each 64-bit product from 32x32 partial products in the single compute stage.
// Reset: synchronous active-low aresetn clears both valid flags; payload is not reset.
module packed_simd128_alu (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // opcode, elem_kind, is_mask, a_lo, a_hi, b_lo, b_hi, c_lo, c_hi, shift_count, zero pad
    input  wire logic [ps128_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_lo, result_hi, ok, zero pad
    output logic [ps128_pkg::OUT_TDATA_W-1:0] m_tdata
);
    ps128_pkg::item_t   in_reg;
    logic               in_vld_reg;
    ps128_pkg::result_t res_reg, res_next;
    logic               res_vld_reg;
    logic               adv;

    logic [63:0] lo_ar, hi_ar, splat;
    logic [3:0]  kind;
    logic        intk, bitk, sgn;
    logic [1:0]  wsel;

    assign adv = in_vld_reg && (!res_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            if (s_tready) in_vld_reg <= s_tvalid;
            if (adv) res_vld_reg <= 1'b1;
            else if (m_tready) res_vld_reg <= 1'b0;
        end
        if (s_tready && s_tvalid) in_reg <= s_tdata[$bits(ps128_pkg::item_t)-1:0];
        if (adv) res_reg <= res_next;
    end

    assign kind = in_reg.elem_kind;
    assign intk = kind < ps128_pkg::KIND_INT_END;
    assign bitk = intk || kind == ps128_pkg::KIND_BOOL;
    assign wsel = kind[2:1];
    assign sgn = !kind[0];

    ps128_lane64 u_lo (.opcode(in_reg.opcode), .wsel(wsel), .sgn(sgn),
        .shamt(in_reg.shift_count[5:0]), .a(in_reg.a_lo), .b(in_reg.b_lo), .r(lo_ar));
    ps128_lane64 u_hi (.opcode(in_reg.opcode), .wsel(wsel), .sgn(sgn),
        .shamt(in_reg.shift_count[5:0]), .a(in_reg.a_hi), .b(in_reg.b_hi), .r(hi_ar));

    always_comb begin
        case (wsel)
            2'd0: splat = {8{in_reg.a_lo[7:0]}};
            2'd1: splat = {4{in_reg.a_lo[15:0]}};
            2'd2: splat = {2{in_reg.a_lo[31:0]}};
            default: splat = in_reg.a_lo;
        endcase
    end

    always_comb begin
        res_next = '0;
        case (in_reg.opcode)
            ps128_pkg::OP_NOT: begin
                res_next.ok = bitk;
                res_next.result_lo = ~in_reg.a_lo;
                res_next.result_hi = ~in_reg.a_hi;
            end
            ps128_pkg::OP_AND: begin
                res_next.ok = bitk;
                res_next.result_lo = in_reg.a_lo & in_reg.b_lo;
                res_next.result_hi = in_reg.a_hi & in_reg.b_hi;
            end
            ps128_pkg::OP_OR: begin
                res_next.ok = bitk;
                res_next.result_lo = in_reg.a_lo | in_reg.b_lo;
                res_next.result_hi = in_reg.a_hi | in_reg.b_hi;
            end
            ps128_pkg::OP_XOR: begin
                res_next.ok = bitk;
                res_next.result_lo = in_reg.a_lo ^ in_reg.b_lo;
                res_next.result_hi = in_reg.a_hi ^ in_reg.b_hi;
            end
            ps128_pkg::OP_SEL: begin
                res_next.ok = bitk;
                res_next.result_lo = (in_reg.a_lo & in_reg.c_lo) | (in_reg.b_lo & ~in_reg.c_lo);
                res_next.result_hi = (in_reg.a_hi & in_reg.c_hi) | (in_reg.b_hi & ~in_reg.c_hi);
            end
            ps128_pkg::OP_SPLAT: begin
                res_next.ok = intk && !in_reg.is_mask;
                res_next.result_lo = splat;
                res_next.result_hi = splat;
            end
            ps128_pkg::OP_ADD, ps128_pkg::OP_SUB, ps128_pkg::OP_SHL, ps128_pkg::OP_SHR,
            ps128_pkg::OP_EQ, ps128_pkg::OP_NE: begin
                res_next.ok = intk && !in_reg.is_mask;
                res_next.result_lo = lo_ar;
                res_next.result_hi = hi_ar;
            end
            ps128_pkg::OP_MUL: begin
                res_next.ok = intk && !in_reg.is_mask && wsel != 2'd0;
                res_next.result_lo = lo_ar;
                res_next.result_hi = hi_ar;
            end
            ps128_pkg::OP_LT, ps128_pkg::OP_LE, ps128_pkg::OP_GT, ps128_pkg::OP_GE: begin
                res_next.ok = intk && !in_reg.is_mask && kind != ps128_pkg::KIND_U64;
                res_next.result_lo = lo_ar;
                res_next.result_hi = hi_ar;
            end
            default: res_next = '0;
        endcase
        // drop data of unsupported combinations
        if (!res_next.ok) begin
            res_next.result_lo = '0;
            res_next.result_hi = '0;
        end
    end

    assign m_tvalid = res_vld_reg;
    assign m_tdata = {{(ps128_pkg::OUT_TDATA_W - $bits(ps128_pkg::result_t)){1'b0}}, res_reg};
endmodule
`default_nettype wire

FILE: rtl/ps128_lane64.sv
`default_nettype none
// One 64-bit half: lane-wise add, sub, mul, compare and shift for all lane widths.
module ps128_lane64 (
    input  wire logic [4:0]  opcode,
    input  wire logic [1:0]  wsel,
    input  wire logic        sgn,
    input  wire logic [5:0]  shamt,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic [63:0]      r
);
    logic [63:0] r8, r16, r32, r64;

    function automatic logic [63:0] lane_fn(input logic [4:0] op, input logic [63:0] x,
                                            input logic [63:0] y, input int w,
                                            input logic sg, input logic [5:0] s);
        logic [63:0] m, sb, xo, yo, sh, res, p_ll, prod;
        logic [31:0] p_x;
        logic t;
        m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        sb = 64'd1 << (w - 1);
        xo = sg ? (x ^ sb) : x;
        yo = sg ? (y ^ sb) : y;
        sh = x >> s;
        // low 64 bits of the product from 32x32 partial products
        p_ll = 64'(x[31:0]) * 64'(y[31:0]);
        p_x = x[31:0] * y[63:32] + x[63:32] * y[31:0];
        prod = p_ll + {p_x, 32'd0};
        t = 1'b0;
        res = '0;
        case (op)
            ps128_pkg::OP_ADD: res = (x + y) & m;
            ps128_pkg::OP_SUB: res = (x - y) & m;
            ps128_pkg::OP_MUL: res = prod & m;
            ps128_pkg::OP_EQ:  t = (x == y);
            ps128_pkg::OP_NE:  t = (x != y);
            ps128_pkg::OP_LT:  t = (xo < yo);
            ps128_pkg::OP_LE:  t = (xo <= yo);
            ps128_pkg::OP_GT:  t = (xo > yo);
            ps128_pkg::OP_GE:  t = (xo >= yo);
            ps128_pkg::OP_SHL: res = (x << s) & m;
            ps128_pkg::OP_SHR: res = (sg && ((x & sb) != '0)) ? (sh | (m & ~(m >> s))) : sh;
            default: res = '0;
        endcase
        if (t) res = m;
        return res;
    endfunction

    always_comb begin
        for (int k = 0; k < 8; k++)
            r8[k*8 +: 8] = 8'(lane_fn(opcode, {56'd0, a[k*8 +: 8]}, {56'd0, b[k*8 +: 8]},
                                      8, sgn, {3'd0, shamt[2:0]}));
        for (int k = 0; k < 4; k++)
            r16[k*16 +: 16] = 16'(lane_fn(opcode, {48'd0, a[k*16 +: 16]},
                                          {48'd0, b[k*16 +: 16]},
                                          16, sgn, {2'd0, shamt[3:0]}));
        for (int k = 0; k < 2; k++)
            r32[k*32 +: 32] = 32'(lane_fn(opcode, {32'd0, a[k*32 +: 32]},
                                          {32'd0, b[k*32 +: 32]},
                                          32, sgn, {1'b0, shamt[4:0]}));
        r64 = lane_fn(opcode, a, b, 64, sgn, shamt);
        case (wsel)
            2'd0: r = r8;
            2'd1: r = r16;
            2'd2: r = r32;
            default: r = r64;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/ps128_checker.sv
`default_nettype none
module ps128_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_zero_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[128] |-> m_tdata[127:0] == 128'd0)
        else $error("unsupported item carries data");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[135:129] == 7'd0)
        else $error("pad bits set");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind packed_simd128_alu ps128_checker u_chk (.aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire
